### hw/rtl/fcpts_pkg.sv
// ----------------------------------------------------------------------------
// fcpts_pkg
// Shared types, constants and the phase time function for the four channel
// pulse train sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpts_pkg;

    localparam int CHANNELS    = 4;
    localparam int PHASES      = 8;
    localparam int PHASE_W     = 3;
    localparam int COUNT_W     = 16;
    localparam int CMP_W       = 18;
    localparam int STEP_W      = 10;
    localparam int BASE_W      = 12;
    localparam int SPACING_W   = 13;
    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PERIOD  = 8'd0,
        REG_STEP    = 8'd1,
        REG_BASE    = 8'd2,
        REG_SPACING = 8'd3,
        REG_WORD0   = 8'd4,
        REG_WORD1   = 8'd5,
        REG_WORD2   = 8'd6,
        REG_WORD3   = 8'd7
    } cfg_reg_t;

    localparam logic [COUNT_W-1:0]   PERIOD_RST  = 16'd11584;
    localparam logic [STEP_W-1:0]    STEP_RST    = 10'd22;
    localparam logic [BASE_W-1:0]    BASE_RST    = 12'd181;
    localparam logic [SPACING_W-1:0] SPACING_RST = 13'd732;
    localparam logic [WORD_W-1:0]    WORD0_RST   = 32'd146800940;
    localparam logic [WORD_W-1:0]    WORD1_RST   = 32'd9505830;
    localparam logic [WORD_W-1:0]    WORD2_RST   = 32'd139597600;
    localparam logic [WORD_W-1:0]    WORD3_RST   = 32'd2302490;

    // timing settings shared by every channel
    typedef struct packed {
        logic [STEP_W-1:0]    step;
        logic [BASE_W-1:0]    base;
        logic [SPACING_W-1:0] spacing;
    } chan_cfg_t;

    // compare time of phase k for a channel word, kept to CMP_W bits
    function automatic logic [CMP_W-1:0] phase_time(
        input logic [WORD_W-1:0]  word,
        input logic [PHASE_W-1:0] k,
        input chan_cfg_t          cfg
    );
        logic [1:0]   slot;
        logic [3:0]   nib;
        logic [14:0]  slot_ofs;
        logic [13:0]  width_ofs;
        logic [CMP_W-1:0] t;
        slot = k[2:1];
        unique case (slot)
            2'd0: nib = word[19:16];
            2'd1: nib = word[23:20];
            2'd2: nib = word[27:24];
            2'd3: nib = word[31:28];
            default: nib = word[19:16];
        endcase
        slot_ofs  = {13'd0, slot} * {2'd0, cfg.spacing};
        width_ofs = {10'd0, nib} * {4'd0, cfg.step};
        t = {2'd0, word[15:0]} + {3'd0, slot_ofs};
        if (k[0])
        begin
            t = t + {6'd0, cfg.base} + {4'd0, width_ofs};
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fcpts_channel.sv
// ----------------------------------------------------------------------------
// fcpts_channel
// One output compare channel: compare register, phase index and pin level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpts_channel (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire logic [fcpts_pkg::COUNT_W-1:0] count,
    input  wire logic [fcpts_pkg::COUNT_W-1:0] period,
    input  wire logic [fcpts_pkg::WORD_W-1:0]  word,
    input  wire fcpts_pkg::chan_cfg_t          cfg,
    output logic                               pin_next,
    output logic                               match
);
    import fcpts_pkg::*;

    logic [CMP_W-1:0]   compare_reg;
    logic [CMP_W-1:0]   compare_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               pin_reg;

    assign match = fire && (compare_reg < {2'd0, period})
                        && (compare_reg == {2'd0, count});

    always_comb
    begin
        compare_next = compare_reg;
        phase_next   = phase_reg;
        pin_next     = pin_reg;
        if (match)
        begin
            pin_next     = phase_reg[0];
            compare_next = phase_time(word, phase_reg, cfg);
            phase_next   = phase_reg + PHASE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_reg <= '0;
            phase_reg   <= '0;
            pin_reg     <= 1'b0;
        end
        else
        begin
            compare_reg <= compare_next;
            phase_reg   <= phase_next;
            pin_reg     <= pin_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/four_channel_pulse_train_sequencer.sv
// ----------------------------------------------------------------------------
// four_channel_pulse_train_sequencer
// Period counter with four output compare channels, each emitting a train of
// four data-modulated pulses per period.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one beat per timer tick; tick=1 advances the counter and
//                 runs the compares, tick=0 leaves the timer state as it is.
//   out channel : one beat per input beat with pin_levels (after the tick),
//                 match_flags and the counter value that was compared.
//   cfg channel : register index and data, always ready; write only while
//                 no beat is in flight.
// The output beat appears in the cycle after its input beat. Throughput is
// one beat per cycle while the receiver keeps up: the compares, reloads and
// counter step all happen in the cycle an input beat is taken, and the
// results sit in one output register. When the receiver stalls, the output
// register holds and in_ready drops until the held beat is taken. Reset
// loads the default registers, clears the counter, compare values, phase
// indexes and pins, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_pulse_train_sequencer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              tick,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [3:0]                             pin_levels,
    output logic [3:0]                             match_flags,
    output logic [15:0]                            counter_value,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fcpts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [fcpts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fcpts_pkg::*;

    logic [COUNT_W-1:0]   period_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [SPACING_W-1:0] spacing_reg;
    logic [WORD_W-1:0]    word_reg [CHANNELS];

    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [COUNT_W:0]     count_inc;

    logic                 out_valid_reg;
    logic [3:0]           pins_reg;
    logic [3:0]           flags_reg;
    logic [COUNT_W-1:0]   cnt_out_reg;

    logic                 accept;
    logic                 fire;
    chan_cfg_t            cfg;
    logic [CHANNELS-1:0]  pin_next;
    logic [CHANNELS-1:0]  match;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign fire      = accept && tick;

    assign cfg.step    = step_reg;
    assign cfg.base    = base_reg;
    assign cfg.spacing = spacing_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RST;
            step_reg    <= STEP_RST;
            base_reg    <= BASE_RST;
            spacing_reg <= SPACING_RST;
            word_reg[0] <= WORD0_RST;
            word_reg[1] <= WORD1_RST;
            word_reg[2] <= WORD2_RST;
            word_reg[3] <= WORD3_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PERIOD:  period_reg  <= cfg_data[COUNT_W-1:0];
                REG_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                REG_BASE:    base_reg    <= cfg_data[BASE_W-1:0];
                REG_SPACING: spacing_reg <= cfg_data[SPACING_W-1:0];
                REG_WORD0:   word_reg[0] <= cfg_data[WORD_W-1:0];
                REG_WORD1:   word_reg[1] <= cfg_data[WORD_W-1:0];
                REG_WORD2:   word_reg[2] <= cfg_data[WORD_W-1:0];
                REG_WORD3:   word_reg[3] <= cfg_data[WORD_W-1:0];
                default:     ;
            endcase
        end
    end

    // period counter, wraps also when the period was shrunk below it
    assign count_inc = {1'b0, count_reg} + (COUNT_W+1)'(1);

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (count_inc >= {1'b0, period_reg})
                count_next = '0;
            else
                count_next = count_inc[COUNT_W-1:0];
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        fcpts_channel u_chan (
            .clk      (clk),
            .rst_n    (rst_n),
            .fire     (fire),
            .count    (count_reg),
            .period   (period_reg),
            .word     (word_reg[i % 4]),
            .cfg      (cfg),
            .pin_next (pin_next[i]),
            .match    (match[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pins_reg    <= pin_next;
            flags_reg   <= match;
            cnt_out_reg <= count_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pin_levels    = pins_reg;
    assign match_flags   = flags_reg;
    assign counter_value = cnt_out_reg;

endmodule

`default_nettype wire

### bench/four_channel_pulse_train_sequencer_tb.sv
// ----------------------------------------------------------------------------
// four_channel_pulse_train_sequencer_tb
// Drives timer tick beats through the pulse train sequencer while the output
// side stalls on its own pattern. A local timer and compare model predicts
// pins, match flags and compared count for every beat. Register settings are
// changed between runs, once all pending beats are back.
// ----------------------------------------------------------------------------
module four_channel_pulse_train_sequencer_tb;

    import fcpts_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_REG = 8'd8;
    localparam logic [CFG_INDEX_W-1:0] LAST_UNUSED_REG  = 8'hFF;

    typedef struct packed {
        logic [3:0]  pins;
        logic [3:0]  flags;
        logic [15:0] count;
    } beat_t;

    typedef struct packed {
        logic                   is_write;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   tick_bit;
        logic                   known;
        beat_t                  want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   tick;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [3:0]             pin_levels;
    logic [3:0]             match_flags;
    logic [15:0]            counter_value;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // timer model state and settings
    logic [COUNT_W-1:0]   m_period;
    logic [STEP_W-1:0]    m_step;
    logic [BASE_W-1:0]    m_base;
    logic [SPACING_W-1:0] m_spacing;
    logic [WORD_W-1:0]    m_word [CHANNELS];
    logic [COUNT_W-1:0]   m_count;
    logic [PHASE_W-1:0]   m_phase [CHANNELS];
    logic [CMP_W-1:0]     m_cmp [CHANNELS];
    logic [CHANNELS-1:0]  m_pins;

    beat_t       pending_q [$];
    plan_row_t   plan_q [$];
    beat_t       front_beat;
    int unsigned mismatches = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    int unsigned rx_hold = 0;

    four_channel_pulse_train_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .tick          (tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pin_levels    (pin_levels),
        .match_flags   (match_flags),
        .counter_value (counter_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void reset_model();
        int i;
        m_period  = PERIOD_RST;
        m_step    = STEP_RST;
        m_base    = BASE_RST;
        m_spacing = SPACING_RST;
        m_word[0] = WORD0_RST;
        m_word[1] = WORD1_RST;
        m_word[2] = WORD2_RST;
        m_word[3] = WORD3_RST;
        m_count   = '0;
        m_pins    = '0;
        for (i = 0; i < CHANNELS; i++)
        begin
            m_phase[i] = '0;
            m_cmp[i]   = '0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_PERIOD:  m_period  = d[COUNT_W-1:0];
            REG_STEP:    m_step    = d[STEP_W-1:0];
            REG_BASE:    m_base    = d[BASE_W-1:0];
            REG_SPACING: m_spacing = d[SPACING_W-1:0];
            REG_WORD0:   m_word[0] = d;
            REG_WORD1:   m_word[1] = d;
            REG_WORD2:   m_word[2] = d;
            REG_WORD3:   m_word[3] = d;
            default:     ;
        endcase
    endfunction

    // edge time of phase k: start plus slot offset, odd phases add the width
    function automatic logic [CMP_W-1:0] pulse_edge_time(input int ch,
                                                         input logic [PHASE_W-1:0] k);
        logic [1:0]  slot;
        logic [3:0]  nib;
        int unsigned t;
        slot = k[2:1];
        nib  = m_word[ch][16 + 4*slot +: 4];
        t    = m_word[ch][15:0] + slot * m_spacing;
        if (k[0])
        begin
            t = t + m_base + nib * m_step;
        end
        return t[CMP_W-1:0];
    endfunction

    function automatic beat_t advance_timer(input logic t);
        beat_t b;
        int    i;
        b.flags = '0;
        b.count = m_count;
        if (t)
        begin
            for (i = 0; i < CHANNELS; i++)
            begin
                if (m_cmp[i] < m_period && m_cmp[i] == m_count)
                begin
                    m_pins[i]  = m_phase[i][0];
                    m_cmp[i]   = pulse_edge_time(i, m_phase[i]);
                    m_phase[i] = m_phase[i] + 1'b1;
                    b.flags[i] = 1'b1;
                end
            end
            // a counter at or above a shrunk period wraps right away
            if ({1'b0, m_count} + 17'd1 >= {1'b0, m_period})
                m_count = '0;
            else
                m_count = m_count + 1'b1;
        end
        b.pins = m_pins;
        return b;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        plan_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.data     = d;
        plan_q.push_back(r);
    endfunction

    function automatic void add_tick(input logic t);
        plan_row_t r;
        r          = '0;
        r.tick_bit = t;
        plan_q.push_back(r);
    endfunction

    function automatic void add_known(input logic t, input logic [3:0] pins,
                                      input logic [3:0] flags, input logic [15:0] count);
        plan_row_t r;
        r            = '0;
        r.tick_bit   = t;
        r.known      = 1'b1;
        r.want.pins  = pins;
        r.want.flags = flags;
        r.want.count = count;
        plan_q.push_back(r);
    endfunction

    function automatic void build_plan();
        // idle beat after reset
        add_known(1'b0, 4'h0, 4'h0, 16'd0);
        add_write(REG_WORD0, 32'h1234_0003);
        add_write(REG_WORD1, 32'h0000_0000);
        add_write(REG_WORD2, 32'hFFFF_0005);
        add_write(REG_WORD3, 32'h5A5A_0002);
        // upper bits are junk and must be masked off
        add_write(REG_STEP, 32'hFFFF_FC01);
        add_write(REG_BASE, 32'hFFFF_F002);
        add_write(REG_SPACING, 32'hFFFF_E004);
        // cleared compares all hit at count zero
        add_known(1'b1, 4'h0, 4'hF, 16'd0);
        add_known(1'b1, 4'h0, 4'h0, 16'd1);
        // odd phases drive the pin high
        add_known(1'b1, 4'h8, 4'h8, 16'd2);
        add_known(1'b1, 4'h9, 4'h1, 16'd3);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        // zero period: no compare matches and the counter stays at zero
        add_write(REG_PERIOD, 32'h0000_0000);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b0);
        add_write(REG_PERIOD, 32'hFFFF_0001);
        add_tick(1'b1);
        add_tick(1'b1);
        add_write(FIRST_UNUSED_REG, 32'hFFFF_FFFF);
        add_write(REG_PERIOD, 32'd40);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
    endfunction

    task automatic push_tick(input logic t, input logic known, input beat_t want);
        beat_t b;
        in_valid <= 1'b1;
        tick     <= t;
        do @(posedge clk); while (!in_ready);
        b = advance_timer(t);
        pending_q.push_back(known ? want : b);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, d);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] small_word();
        logic [WORD_W-1:0] w;
        w       = $urandom();
        w[15:0] = 16'($urandom_range(0, 15));
        return w;
    endfunction

    // new short timing, then mostly a period that keeps every compare reachable
    task automatic pick_timing();
        logic [CFG_DATA_W-1:0] d;
        int unsigned           top;
        int                    ch;
        int                    k;
        if ($urandom_range(0, 1))
        begin
            d = $urandom();
            d[STEP_W-1:0] = STEP_W'($urandom_range(0, 2));
            write_reg(REG_STEP, d);
        end
        if ($urandom_range(0, 1))
        begin
            d = $urandom();
            d[BASE_W-1:0] = BASE_W'($urandom_range(0, 6));
            write_reg(REG_BASE, d);
        end
        if ($urandom_range(0, 1))
        begin
            d = $urandom();
            d[SPACING_W-1:0] = SPACING_W'($urandom_range(0, 12));
            write_reg(REG_SPACING, d);
        end
        if ($urandom_range(0, 1)) write_reg(REG_WORD0, small_word());
        if ($urandom_range(0, 1)) write_reg(REG_WORD1, small_word());
        if ($urandom_range(0, 1)) write_reg(REG_WORD2, small_word());
        if ($urandom_range(0, 1)) write_reg(REG_WORD3, small_word());
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(LAST_UNUSED_REG, FIRST_UNUSED_REG)),
                      $urandom());
        top = 0;
        for (ch = 0; ch < CHANNELS; ch++)
        begin
            if (m_cmp[ch] > top) top = m_cmp[ch];
            for (k = 0; k < PHASES; k++)
            begin
                if (pulse_edge_time(ch, k[2:0]) > top) top = pulse_edge_time(ch, k[2:0]);
            end
        end
        d = $urandom();
        case ($urandom_range(0, 7))
            0:       d[COUNT_W-1:0] = COUNT_W'($urandom_range(0, m_count));
            1:       d[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 3));
            default: d[COUNT_W-1:0] = COUNT_W'(top + 1 + $urandom_range(0, 24));
        endcase
        write_reg(REG_PERIOD, d);
    endtask

    // receiver: ready always, coin flips, or long stalls, switching now and then
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(16, 96);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    rx_hold = $urandom_range(1, 8);
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                flag_mismatch("beat with nothing pending, count", counter_value, 0);
            end
            else
            begin
                front_beat = pending_q.pop_front();
                if (pin_levels !== front_beat.pins)
                    flag_mismatch("pin_levels", pin_levels, front_beat.pins);
                if (match_flags !== front_beat.flags)
                    flag_mismatch("match_flags", match_flags, front_beat.flags);
                if (counter_value !== front_beat.count)
                    flag_mismatch("counter_value", counter_value, front_beat.count);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned run_len;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned n;
        logic        steady;
        plan_row_t   row;
        in_valid    = 1'b0;
        tick        = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        random_sent = 0;
        burst_left  = 0;
        reset_model();
        build_plan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            row = plan_q[i];
            if (row.is_write)
            begin
                if (in_valid) drain_results();
                write_reg(row.idx, row.data);
            end
            else
            begin
                if (cfg_valid) cfg_valid <= 1'b0;
                push_tick(row.tick_bit, row.known, row.want);
            end
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            drain_results();
            pick_timing();
            cfg_valid <= 1'b0;
            run_len = $urandom_range(40, 140);
            if (run_len > RANDOM_ITEMS - random_sent)
                run_len = RANDOM_ITEMS - random_sent;
            steady  = ($urandom_range(0, 3) == 0);
            for (n = 0; n < run_len; n++)
            begin
                if (burst_left == 0)
                begin
                    gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                push_tick($urandom_range(0, 7) != 0, 1'b0, '0);
                random_sent++;
            end
        end

        // widest settings last, so their huge compares strand nothing later
        drain_results();
        write_reg(REG_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_STEP, 32'hFFFF_FFFF);
        write_reg(REG_BASE, 32'hFFFF_FFFF);
        write_reg(REG_SPACING, 32'hFFFF_FFFF);
        write_reg(REG_WORD0, 32'hFFFF_FFFF);
        write_reg(REG_WORD1, 32'hFFFF_FFFF);
        write_reg(REG_WORD2, 32'hFFFF_FFFF);
        write_reg(REG_WORD3, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        for (n = 0; n < 30; n++)
        begin
            push_tick(1'b1, 1'b0, '0);
        end

        drain_results();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
